/* sv/tmcw_pkg.sv */
package tmcw_pkg;

	// default screen geometry
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// field widths
	localparam int MODE_W      = 3;
	localparam int CHAR_W      = 8;
	localparam int ATTR_W      = 8;
	localparam int CELL_W      = CHAR_W + ATTR_W;
	localparam int IN_ADDR_W   = 11;
	localparam int PROT_W      = 7;
	localparam int OUT_IDX_W   = 11;
	localparam int OUT_COL_W   = 7;
	localparam int OUT_ROW_W   = 5;
	localparam int S_TDATA_W   = 32;
	localparam int M_TDATA_W   = 40;

	// reset and fill values
	localparam logic [PROT_W-1:0] PROT_RESET = 7'd18;
	localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
	localparam logic [ATTR_W-1:0] CLEAR_ATTR = 8'h07;
	localparam logic [CELL_W-1:0] CLEAR_CELL = {CLEAR_ATTR, BLANK_CHAR};

	// request kinds
	typedef enum logic [MODE_W-1:0] {
		MODE_PUT     = 3'd0,
		MODE_BACK    = 3'd1,
		MODE_NEWLINE = 3'd2,
		MODE_CLEAR   = 3'd3,
		MODE_READ    = 3'd4
	} mode_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCROLL,
		ST_EXEC,
		ST_BS_WR,
		ST_CLEAR,
		ST_RESP
	} state_t;

	// cursor updates
	typedef enum logic [2:0] {
		CUR_NONE,
		CUR_HOME,
		CUR_ADV,
		CUR_BACK,
		CUR_NEWLINE,
		CUR_LAST_ROW
	} cur_op_t;

endpackage

/* sv/text_mode_console_writer.sv */
// channel   dir  signals                    request
// s_*       in   tvalid tready tdata tuser  one character event (tuser: mode)
// m_*       out  tvalid tready tdata        cursor and cell read-back
// cfg_*     in   we wdata                   prompt width (protected columns)
//
// put, newline, read and idle modes pass through exec to the result;
// backspace with erase reads the cell, then writes back a blank char.
// a scroll runs first once the cursor is past the last row;
// clear, and a pass after reset before s_tready, rewrite every cell.
// an item is taken while the previous result still waits in the output
// register; the next result stalls until m_tready frees that register.
module text_mode_console_writer #(
	parameter int COLUMNS = tmcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tmcw_pkg::ROWS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// char_code[7:0], text_attribute[15:8], cell_address[26:16]
	input  logic [tmcw_pkg::S_TDATA_W-1:0]   s_tdata,
	// mode[2:0]
	input  logic [tmcw_pkg::MODE_W-1:0]      s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// cursor_index[10:0], cursor_column[17:11], cursor_row[22:18],
	// cell_char[30:23], cell_attribute[38:31]
	output logic [tmcw_pkg::M_TDATA_W-1:0]   m_tdata,
	input  logic                             cfg_we,
	input  logic [tmcw_pkg::PROT_W-1:0]      cfg_wdata
);

	localparam int CELLS  = ROWS * COLUMNS;
	localparam int IDX_W  = $clog2(CELLS + 1);
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS + 1);

	tmcw_pkg::state_t  state_q, state_d;
	tmcw_pkg::cur_op_t cur_op;
	tmcw_pkg::mode_t   in_mode, mode_q;

	logic [tmcw_pkg::PROT_W-1:0]    prot_q;
	logic [tmcw_pkg::CHAR_W-1:0]    char_q;
	logic [tmcw_pkg::ATTR_W-1:0]    attr_q;
	logic [tmcw_pkg::IN_ADDR_W-1:0] addr_q;
	logic [IDX_W-1:0]               sweep_q, sweep_d;
	logic                           rd_hit_q, rd_hit_d;
	logic                           m_tvalid_q;
	logic [tmcw_pkg::M_TDATA_W-1:0] m_tdata_q;
	logic                           accept, load_out, read_hit;

	logic [IDX_W-1:0]               cur_idx, prev_idx, src_idx;
	logic [COL_W-1:0]               cur_col;
	logic [ROW_W-1:0]               cur_row;
	logic                           cur_end;

	logic                           mem_we, mem_re;
	logic [ADDR_W-1:0]              mem_waddr, mem_raddr;
	logic [tmcw_pkg::CELL_W-1:0]    mem_wdata, mem_rdata;
	logic [tmcw_pkg::CHAR_W-1:0]    out_char;
	logic [tmcw_pkg::ATTR_W-1:0]    out_attr;

	tmcw_screen_ram #(
		.DEPTH(CELLS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	tmcw_cursor #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (cur_op),
		.idx    (cur_idx),
		.col    (cur_col),
		.row    (cur_row),
		.at_end (cur_end)
	);

	// prompt width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prot_q <= tmcw_pkg::PROT_RESET;
		end else if (cfg_we) begin
			prot_q <= cfg_wdata;
		end
	end

	assign s_tready = (state_q == tmcw_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_mode  = tmcw_pkg::mode_t'(s_tuser);
	assign load_out = (state_q == tmcw_pkg::ST_RESP) && (!m_tvalid_q || m_tready);
	assign read_hit = 32'(addr_q) < 32'(CELLS);
	assign prev_idx = cur_idx - IDX_W'(1);
	assign src_idx  = sweep_q + IDX_W'(COLUMNS);

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= in_mode;
			char_q <= s_tdata[7:0];
			attr_q <= s_tdata[15:8];
			addr_q <= s_tdata[26:16];
		end
	end

	// sequencer: next state, memory port and cursor update
	always_comb begin
		state_d   = state_q;
		sweep_d   = sweep_q;
		rd_hit_d  = rd_hit_q;
		cur_op    = tmcw_pkg::CUR_NONE;
		mem_we    = 1'b0;
		mem_waddr = cur_idx[ADDR_W-1:0];
		mem_wdata = tmcw_pkg::CLEAR_CELL;
		mem_re    = 1'b0;
		mem_raddr = ADDR_W'(addr_q);
		unique case (state_q)
			tmcw_pkg::ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q[ADDR_W-1:0];
				sweep_d   = sweep_q + IDX_W'(1);
				if (sweep_q == IDX_W'(CELLS - 1)) begin
					sweep_d = '0;
					state_d = tmcw_pkg::ST_IDLE;
				end
			end
			tmcw_pkg::ST_IDLE: begin
				if (accept) begin
					sweep_d = '0;
					if (cur_end && (in_mode == tmcw_pkg::MODE_PUT ||
							in_mode == tmcw_pkg::MODE_BACK ||
							in_mode == tmcw_pkg::MODE_NEWLINE ||
							in_mode == tmcw_pkg::MODE_CLEAR)) begin
						state_d = tmcw_pkg::ST_SCROLL;
					end else begin
						state_d = tmcw_pkg::ST_EXEC;
					end
				end
			end
			tmcw_pkg::ST_SCROLL: begin
				// read one row ahead, write back in the next cycle; last row gets blanks
				mem_re    = sweep_q < IDX_W'(CELLS - COLUMNS);
				mem_raddr = src_idx[ADDR_W-1:0];
				mem_we    = sweep_q != '0;
				mem_waddr = ADDR_W'(sweep_q - IDX_W'(1));
				if (sweep_q <= IDX_W'(CELLS - COLUMNS)) begin
					mem_wdata = mem_rdata;
				end else begin
					mem_wdata = {attr_q, tmcw_pkg::BLANK_CHAR};
				end
				sweep_d = sweep_q + IDX_W'(1);
				if (sweep_q == IDX_W'(CELLS)) begin
					sweep_d = '0;
					cur_op  = tmcw_pkg::CUR_LAST_ROW;
					state_d = tmcw_pkg::ST_EXEC;
				end
			end
			tmcw_pkg::ST_EXEC: begin
				rd_hit_d = 1'b0;
				state_d  = tmcw_pkg::ST_RESP;
				case (mode_q)
					tmcw_pkg::MODE_PUT: begin
						mem_we    = 1'b1;
						mem_wdata = {attr_q, char_q};
						cur_op    = tmcw_pkg::CUR_ADV;
					end
					tmcw_pkg::MODE_BACK: begin
						if (32'(cur_col) > 32'(prot_q)) begin
							mem_re    = 1'b1;
							mem_raddr = prev_idx[ADDR_W-1:0];
							cur_op    = tmcw_pkg::CUR_BACK;
							state_d   = tmcw_pkg::ST_BS_WR;
						end
					end
					tmcw_pkg::MODE_NEWLINE: begin
						cur_op = tmcw_pkg::CUR_NEWLINE;
					end
					tmcw_pkg::MODE_CLEAR: begin
						sweep_d = '0;
						state_d = tmcw_pkg::ST_CLEAR;
					end
					tmcw_pkg::MODE_READ: begin
						rd_hit_d = read_hit;
						mem_re   = read_hit;
					end
					default: ;
				endcase
			end
			tmcw_pkg::ST_BS_WR: begin
				// cursor already stepped back; keep the attribute, blank the char
				mem_we    = 1'b1;
				mem_wdata = {mem_rdata[tmcw_pkg::CELL_W-1:tmcw_pkg::CHAR_W],
					tmcw_pkg::BLANK_CHAR};
				state_d   = tmcw_pkg::ST_RESP;
			end
			tmcw_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q[ADDR_W-1:0];
				sweep_d   = sweep_q + IDX_W'(1);
				if (sweep_q == IDX_W'(CELLS - 1)) begin
					sweep_d = '0;
					cur_op  = tmcw_pkg::CUR_HOME;
					state_d = tmcw_pkg::ST_RESP;
				end
			end
			tmcw_pkg::ST_RESP: begin
				if (load_out) begin
					state_d = tmcw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tmcw_pkg::ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tmcw_pkg::ST_INIT;
			sweep_q  <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			sweep_q  <= sweep_d;
			rd_hit_q <= rd_hit_d;
		end
	end

	// result register
	assign out_char = rd_hit_q ? mem_rdata[tmcw_pkg::CHAR_W-1:0] : '0;
	assign out_attr = rd_hit_q ? mem_rdata[tmcw_pkg::CELL_W-1:tmcw_pkg::CHAR_W] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {1'b0, out_attr, out_char,
				tmcw_pkg::OUT_ROW_W'(cur_row),
				tmcw_pkg::OUT_COL_W'(cur_col),
				tmcw_pkg::OUT_IDX_W'(cur_idx)};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// cursor index, column and row stay consistent
	a_cursor_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cur_idx) == int'(cur_row) * COLUMNS + int'(cur_col))
		else $error("cursor index out of step with row and column");

	// cursor index never goes beyond one past the last cell, column stays on screen
	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(cur_idx) <= CELLS) && (int'(cur_col) < COLUMNS))
		else $error("cursor beyond screen");

	// no memory write while waiting for a request or a result slot
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tmcw_pkg::ST_IDLE || state_q == tmcw_pkg::ST_RESP) |-> !mem_we)
		else $error("screen write outside an active request");

	// a request taken is always followed by the working states, not idle
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == tmcw_pkg::ST_SCROLL || state_q == tmcw_pkg::ST_EXEC))
		else $error("accepted request not started");

endmodule

/* sv/tmcw_screen_ram.sv */
module tmcw_screen_ram #(
	parameter int DEPTH = tmcw_pkg::COLUMNS_DEF * tmcw_pkg::ROWS_DEF
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [$clog2(DEPTH)-1:0]    waddr,
	input  logic [tmcw_pkg::CELL_W-1:0] wdata,
	input  logic                        re,
	input  logic [$clog2(DEPTH)-1:0]    raddr,
	output logic [tmcw_pkg::CELL_W-1:0] rdata
);

	logic [tmcw_pkg::CELL_W-1:0] mem_q [DEPTH];
	logic [tmcw_pkg::CELL_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/tmcw_cursor.sv */
module tmcw_cursor #(
	parameter int COLUMNS = tmcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tmcw_pkg::ROWS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tmcw_pkg::cur_op_t                   op,
	output logic [$clog2(ROWS*COLUMNS+1)-1:0]   idx,
	output logic [$clog2(COLUMNS)-1:0]          col,
	output logic [$clog2(ROWS+1)-1:0]           row,
	output logic                                at_end
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int IDX_W = $clog2(CELLS + 1);
	localparam int COL_W = $clog2(COLUMNS);
	localparam int ROW_W = $clog2(ROWS + 1);

	logic [IDX_W-1:0] idx_q, idx_d;
	logic [COL_W-1:0] col_q, col_d;
	logic [ROW_W-1:0] row_q, row_d;

	// next cursor position, column and row tracked beside the index
	always_comb begin
		idx_d = idx_q;
		col_d = col_q;
		row_d = row_q;
		case (op)
			tmcw_pkg::CUR_HOME: begin
				idx_d = '0;
				col_d = '0;
				row_d = '0;
			end
			tmcw_pkg::CUR_ADV: begin
				idx_d = idx_q + IDX_W'(1);
				if (col_q == COL_W'(COLUMNS - 1)) begin
					col_d = '0;
					row_d = row_q + ROW_W'(1);
				end else begin
					col_d = col_q + COL_W'(1);
				end
			end
			tmcw_pkg::CUR_BACK: begin
				idx_d = idx_q - IDX_W'(1);
				col_d = col_q - COL_W'(1);
			end
			tmcw_pkg::CUR_NEWLINE: begin
				idx_d = idx_q - IDX_W'(col_q) + IDX_W'(COLUMNS);
				col_d = '0;
				row_d = row_q + ROW_W'(1);
			end
			tmcw_pkg::CUR_LAST_ROW: begin
				idx_d = IDX_W'(CELLS - COLUMNS);
				col_d = '0;
				row_d = ROW_W'(ROWS - 1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			col_q <= '0;
			row_q <= '0;
		end else begin
			idx_q <= idx_d;
			col_q <= col_d;
			row_q <= row_d;
		end
	end

	assign idx    = idx_q;
	assign col    = col_q;
	assign row    = row_q;
	assign at_end = (row_q == ROW_W'(ROWS));

endmodule

/* sim/text_mode_console_writer_checker.sv */
module text_mode_console_writer_checker #(
	parameter int COLUMNS = tmcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tmcw_pkg::ROWS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	// char_code[7:0], text_attribute[15:8], cell_address[26:16]
	input  logic [tmcw_pkg::S_TDATA_W-1:0]   s_tdata,
	// mode[2:0]
	input  logic [tmcw_pkg::MODE_W-1:0]      s_tuser,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	// cursor_index[10:0], cursor_column[17:11], cursor_row[22:18],
	// cell_char[30:23], cell_attribute[38:31]
	input  logic [tmcw_pkg::M_TDATA_W-1:0]   m_tdata,
	input  logic                             cfg_we,
	input  logic [tmcw_pkg::PROT_W-1:0]      cfg_wdata,
	output int                               error_count,
	output int                               pending_count
);

	localparam int CELLS = COLUMNS * ROWS;

	typedef struct {
		logic [tmcw_pkg::OUT_IDX_W-1:0] cursor_index;
		logic [tmcw_pkg::OUT_COL_W-1:0] cursor_column;
		logic [tmcw_pkg::OUT_ROW_W-1:0] cursor_row;
		logic [tmcw_pkg::CHAR_W-1:0]    cell_char;
		logic [tmcw_pkg::ATTR_W-1:0]    cell_attr;
	} cursor_report_t;

	// shadow copy of the screen, cursor and prompt width
	logic [tmcw_pkg::CELL_W-1:0] screen [CELLS];
	int unsigned                 cursor;
	logic [tmcw_pkg::PROT_W-1:0] prompt_width;
	cursor_report_t              expected_reports [$];
	cursor_report_t              oldest;
	int                          fail_total;

	function automatic void blank_screen();
		for (int i = 0; i < CELLS; i++)
			screen[i] = tmcw_pkg::CLEAR_CELL;
	endfunction

	// move rows up by one, bring in a blank last row
	function automatic void scroll_up(logic [tmcw_pkg::ATTR_W-1:0] fill_attr);
		for (int i = 0; i < CELLS - COLUMNS; i++)
			screen[i] = screen[i + COLUMNS];
		for (int i = CELLS - COLUMNS; i < CELLS; i++)
			screen[i] = {fill_attr, tmcw_pkg::BLANK_CHAR};
		cursor = CELLS - COLUMNS;
	endfunction

	// apply one character event, return the cursor report it produces
	function automatic cursor_report_t console_event(logic [tmcw_pkg::MODE_W-1:0] mode,
			logic [tmcw_pkg::CHAR_W-1:0] ch, logic [tmcw_pkg::ATTR_W-1:0] attr,
			logic [tmcw_pkg::IN_ADDR_W-1:0] addr);
		cursor_report_t r;
		int unsigned    col;
		r = '{default: '0};
		if (mode <= tmcw_pkg::MODE_CLEAR && cursor >= CELLS)
			scroll_up(attr);
		case (mode)
			tmcw_pkg::MODE_PUT: begin
				screen[cursor] = {attr, ch};
				cursor++;
			end
			tmcw_pkg::MODE_BACK: begin
				col = cursor % COLUMNS;
				// erase only past the prompt
				if (col > prompt_width) begin
					cursor--;
					screen[cursor][tmcw_pkg::CHAR_W-1:0] = tmcw_pkg::BLANK_CHAR;
				end
			end
			tmcw_pkg::MODE_NEWLINE: cursor = (cursor / COLUMNS + 1) * COLUMNS;
			tmcw_pkg::MODE_CLEAR: begin
				blank_screen();
				cursor = 0;
			end
			tmcw_pkg::MODE_READ: begin
				if (addr < CELLS)
					{r.cell_attr, r.cell_char} = screen[addr];
			end
			default: ;
		endcase
		r.cursor_index  = tmcw_pkg::OUT_IDX_W'(cursor);
		r.cursor_column = tmcw_pkg::OUT_COL_W'(cursor % COLUMNS);
		r.cursor_row    = tmcw_pkg::OUT_ROW_W'(cursor / COLUMNS);
		return r;
	endfunction

	function automatic void check_field(string label, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
			fail_total++;
		end
	endfunction

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_screen();
			cursor = 0;
			prompt_width = tmcw_pkg::PROT_RESET;
			expected_reports.delete();
			fail_total = 0;
			error_count <= 0;
			pending_count <= 0;
		end else begin
			if (cfg_we)
				prompt_width = cfg_wdata;
			// results come from earlier requests, so compare before queuing
			if (m_tvalid && m_tready) begin
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual tdata %h",
						$time, m_tdata);
					fail_total++;
				end else begin
					oldest = expected_reports.pop_front();
					check_field("cursor_index", 32'(oldest.cursor_index),
						32'(m_tdata[10:0]));
					check_field("cursor_column", 32'(oldest.cursor_column),
						32'(m_tdata[17:11]));
					check_field("cursor_row", 32'(oldest.cursor_row),
						32'(m_tdata[22:18]));
					check_field("cell_char", 32'(oldest.cell_char),
						32'(m_tdata[30:23]));
					check_field("cell_attribute", 32'(oldest.cell_attr),
						32'(m_tdata[38:31]));
				end
			end
			if (s_tvalid && s_tready)
				expected_reports.push_back(console_event(s_tuser, s_tdata[7:0],
					s_tdata[15:8], s_tdata[26:16]));
			error_count <= fail_total;
			pending_count <= expected_reports.size();
		end
	end

endmodule

/* sim/text_mode_console_writer_tb.sv */
module text_mode_console_writer_tb;

	localparam int LONG_HOLD   = 400;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 235;
	localparam int MODE_MAX    = (1 << tmcw_pkg::MODE_W) - 1;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [tmcw_pkg::S_TDATA_W-1:0]   s_tdata = '0;
	logic [tmcw_pkg::MODE_W-1:0]      s_tuser = '0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [tmcw_pkg::M_TDATA_W-1:0]   m_tdata;
	logic                             cfg_we = 1'b0;
	logic [tmcw_pkg::PROT_W-1:0]      cfg_wdata = '0;
	int                               error_count;
	int                               pending_count;

	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	bit          hold_req = 1'b0;
	bit          hold_done = 1'b0;

	// idle percentages per phase: none, sender, receiver, both
	int unsigned tx_plan [4] = '{0, 59, 0, 7};
	int unsigned rx_plan [4] = '{0, 0, 59, 7};
	// prompt widths per phase, negative picks a random one
	int          prompt_plan [PHASES] = '{0, 79, 40, -1, 1, 78,
		int'(tmcw_pkg::PROT_RESET), -1};

	text_mode_console_writer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	text_mode_console_writer_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.error_count   (error_count),
		.pending_count (pending_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// give up on a hung run
	initial begin
		#30_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// result side: random stalls plus one long hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// offer one request and wait until it is taken
	task automatic send_event(logic [tmcw_pkg::MODE_W-1:0] mode,
			logic [tmcw_pkg::CHAR_W-1:0] ch, logic [tmcw_pkg::ATTR_W-1:0] attr,
			logic [tmcw_pkg::IN_ADDR_W-1:0] addr);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= tmcw_pkg::S_TDATA_W'({addr, attr, ch});
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
	endtask

	task automatic set_prompt_width(logic [tmcw_pkg::PROT_W-1:0] width);
		cfg_we <= 1'b1;
		cfg_wdata <= width;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// typing-like mix: mostly text, some editing, rare clears
	task automatic random_event();
		int unsigned                    pick;
		logic [tmcw_pkg::MODE_W-1:0]    kind;
		logic [tmcw_pkg::IN_ADDR_W-1:0] addr;
		pick = $urandom_range(999);
		addr = ($urandom_range(4) == 0)
			? tmcw_pkg::IN_ADDR_W'($urandom_range((1 << tmcw_pkg::IN_ADDR_W) - 1))
			: tmcw_pkg::IN_ADDR_W'($urandom_range(
				tmcw_pkg::COLUMNS_DEF * tmcw_pkg::ROWS_DEF - 1));
		if (pick < 4)
			kind = tmcw_pkg::MODE_CLEAR;
		else if (pick < 550)
			kind = tmcw_pkg::MODE_PUT;
		else if (pick < 700)
			kind = tmcw_pkg::MODE_BACK;
		else if (pick < 800)
			kind = tmcw_pkg::MODE_NEWLINE;
		else if (pick < 970)
			kind = tmcw_pkg::MODE_READ;
		else
			kind = tmcw_pkg::MODE_W'($urandom_range(MODE_MAX,
				int'(tmcw_pkg::MODE_READ) + 1));
		send_event(kind, tmcw_pkg::CHAR_W'($urandom), tmcw_pkg::ATTR_W'($urandom), addr);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reads at the screen edges and past the end, at reset contents
		send_event(tmcw_pkg::MODE_READ, 8'h00, 8'h00, 11'd0);
		send_event(tmcw_pkg::MODE_READ, 8'h00, 8'h00, 11'd1999);
		send_event(tmcw_pkg::MODE_READ, 8'hFF, 8'hFF, 11'd2000);
		send_event(tmcw_pkg::MODE_READ, 8'h00, 8'h00, 11'd2047);
		// extreme bytes, then read them back
		send_event(tmcw_pkg::MODE_PUT, 8'h00, 8'h00, 11'd0);
		send_event(tmcw_pkg::MODE_PUT, 8'hFF, 8'hFF, 11'd2047);
		send_event(tmcw_pkg::MODE_READ, 8'h00, 8'h00, 11'd0);
		send_event(tmcw_pkg::MODE_READ, 8'h00, 8'h00, 11'd1);
		// backspace inside the reset prompt does nothing
		send_event(tmcw_pkg::MODE_BACK, 8'h00, 8'h00, 11'd0);
		// newline on the top row
		send_event(tmcw_pkg::MODE_NEWLINE, 8'h00, 8'h00, 11'd0);
		send_event(tmcw_pkg::MODE_W'(int'(tmcw_pkg::MODE_READ) + 1), 8'hFF, 8'hFF, 11'd5);
		send_event(tmcw_pkg::MODE_W'(MODE_MAX), 8'h55, 8'hAA, 11'd2047);
		send_event(tmcw_pkg::MODE_READ, 8'h00, 8'h00, 11'd80);
		send_event(tmcw_pkg::MODE_CLEAR, 8'h41, 8'hAA, 11'd0);
		send_event(tmcw_pkg::MODE_READ, 8'h00, 8'h00, 11'd1);

		// no prompt: backspace erases the character, keeps the attribute
		wait_drained();
		set_prompt_width('0);
		send_event(tmcw_pkg::MODE_PUT, 8'h41, 8'h1E, 11'd0);
		send_event(tmcw_pkg::MODE_BACK, 8'h00, 8'h00, 11'd0);
		send_event(tmcw_pkg::MODE_READ, 8'h00, 8'h00, 11'd0);
		send_event(tmcw_pkg::MODE_BACK, 8'h00, 8'h00, 11'd0);

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			set_prompt_width(tmcw_pkg::PROT_W'(prompt_plan[p] < 0
				? $urandom_range(tmcw_pkg::COLUMNS_DEF - 1) : prompt_plan[p]));
			tx_idle_pct = tx_plan[p % 4];
			rx_idle_pct = rx_plan[p % 4];
			// back up the output while requests keep coming
			if (p == 4)
				hold_req = 1'b1;
			repeat (PHASE_ITEMS) random_event();
		end

		wait_drained();
		repeat (16) @(posedge clk);
		if (error_count == 0 && pending_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
